// ===== sv/sfpa_pkg.sv =====
// Shared types, command codes and constants for the saturating fixed-point ALU.
package sfpa_pkg;

  localparam int WordW = 32;
  localparam int CmdW = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_CMP      = 4'd4,
    CMD_MIN      = 4'd5,
    CMD_MAX      = 4'd6,
    CMD_ABS      = 4'd7,
    CMD_INC      = 4'd8,
    CMD_DEC      = 4'd9,
    CMD_FROM_INT = 4'd10,
    CMD_TO_INT   = 4'd11
  } cmd_t;

  // Work item that travels down the divider chain. Results that need no
  // division are formed at entry and ride along.
  typedef struct packed {
    logic             valid;
    logic [CmdW-1:0]  command;
    logic             quo_neg;
    logic [63:0]      rem;
    logic [63:0]      quo;
    logic [31:0]      divisor;
    logic [31:0]      value;
    logic             lt;
    logic             eq;
    logic             gt;
    logic             sat;
    logic             dz;
  } item_t;

endpackage

// ===== sv/sfpa_div_cell.sv =====
// One cell of the divider chain: a register stage plus Steps restoring steps.
module sfpa_div_cell #(
  parameter int Steps = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  sfpa_pkg::item_t din,
  output sfpa_pkg::item_t dout
);
  import sfpa_pkg::*;

  item_t stage;
  item_t stage_next;

  always_comb begin
    logic [64:0] trial;
    logic [63:0] shifted;
    stage_next = din;
    for (int s = 0; s < Steps; s++) begin
      // Shift the next dividend bit into the partial remainder and try.
      shifted = {stage_next.rem[62:0], stage_next.quo[63]};
      trial = {1'b0, shifted} - {33'd0, stage_next.divisor};
      stage_next.quo = {stage_next.quo[62:0], 1'b0};
      if (!trial[64]) begin
        stage_next.rem = trial[63:0];
        stage_next.quo[0] = 1'b1;
      end else begin
        stage_next.rem = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage <= stage_next;
    end
  end

  assign dout = stage;
endmodule

// ===== sv/sfpa_entry.sv =====
// Entry stage: decodes the command and forms every non-divide result.
module sfpa_entry #(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       in_valid,
  input  logic [sfpa_pkg::CmdW-1:0]  command,
  input  logic signed [31:0]         operand_a,
  input  logic signed [31:0]         operand_b,
  output sfpa_pkg::item_t            dout
);
  import sfpa_pkg::*;

  localparam logic signed [31:0] MaxW = 32'sh7fffffff;
  localparam logic signed [31:0] MinW = 32'sh80000000;

  item_t stage;
  item_t stage_next;
  logic signed [63:0] prod_q;
  logic               mul_q;

  always_comb begin
    logic signed [32:0] sum;
    logic signed [63:0] wide;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    stage_next = '0;
    stage_next.valid = in_valid;
    stage_next.command = command;
    mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
    mag_b = operand_b[31] ? 32'(-operand_b) : operand_b;
    sum = '0;
    wide = '0;
    unique case (command)
      CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
        priority case (command)
          CMD_ADD: sum = 33'(operand_a) + 33'(operand_b);
          CMD_SUB: sum = 33'(operand_a) - 33'(operand_b);
          CMD_INC: sum = 33'(operand_a) + 33'sd1;
          default: sum = 33'(operand_a) - 33'sd1;
        endcase
        if (sum[32] != sum[31]) begin
          stage_next.sat = 1'b1;
          stage_next.value = sum[32] ? MinW : MaxW;
        end else begin
          stage_next.value = sum[31:0];
        end
      end
      CMD_DIV: begin
        if (operand_b == 32'sd0) begin
          stage_next.dz = 1'b1;
        end else begin
          stage_next.quo = {32'd0, mag_a} << FRAC_BITS;
          stage_next.divisor = mag_b;
          stage_next.quo_neg = operand_a[31] ^ operand_b[31];
        end
      end
      CMD_CMP: begin
        stage_next.lt = operand_a < operand_b;
        stage_next.eq = operand_a == operand_b;
        stage_next.gt = operand_a > operand_b;
      end
      CMD_MIN: stage_next.value = (operand_a < operand_b) ? operand_a : operand_b;
      CMD_MAX: stage_next.value = (operand_a > operand_b) ? operand_a : operand_b;
      CMD_ABS: begin
        if (operand_a == MinW) begin
          stage_next.value = MaxW;
          stage_next.sat = 1'b1;
        end else begin
          stage_next.value = mag_a;
        end
      end
      CMD_FROM_INT: begin
        wide = 64'(operand_a) <<< FRAC_BITS;
        if (wide > 64'(MaxW)) begin
          stage_next.value = MaxW;
          stage_next.sat = 1'b1;
        end else if (wide < 64'(MinW)) begin
          stage_next.value = MinW;
          stage_next.sat = 1'b1;
        end else begin
          stage_next.value = wide[31:0];
        end
      end
      CMD_TO_INT: stage_next.value = operand_a >>> FRAC_BITS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (advance) begin
      stage <= stage_next;
      prod_q <= operand_a * operand_b;
      mul_q <= command == CMD_MUL;
    end
  end

  // The product is registered; its shift and clamp land in the outgoing item.
  always_comb begin
    logic signed [63:0] sh;
    sh = prod_q >>> FRAC_BITS;
    dout = stage;
    if (mul_q) begin
      if (sh > 64'sh7fffffff) begin
        dout.value = MaxW;
        dout.sat = 1'b1;
      end else if (sh < -64'sh80000000) begin
        dout.value = MinW;
        dout.sat = 1'b1;
      end else begin
        dout.value = sh[31:0];
      end
    end
  end
endmodule

// ===== sv/saturating_fixed_point_alu.sv =====
// Saturating signed fixed-point ALU: decode stage, divider cell chain, output.
// Accepts one transaction per cycle when not stalled and returns results in
// order. It is built from an entry stage (operand decode, 32x32 multiply), a
// chain of 32 divider cells doing two restoring quotient bits each over the
// 64-bit scaled dividend, then a sign/clamp output register. Every command
// goes through the same chain so order is preserved. Stalls freeze the chain.
module saturating_fixed_point_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] command, [35:4] operand_a, [67:36] operand_b, [71:68] zero
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] result_value, [32] less_flag, [33] equal_flag, [34] greater_flag,
  // [35] saturated_flag, [36] divide_by_zero, [39:37] zero
  output logic [39:0] m_tdata
);
  import sfpa_pkg::*;

  localparam int Cells = 32;

  item_t chain [Cells+1];
  logic advance;
  logic [39:0] out_data;
  logic        out_valid;

  assign advance  = !out_valid || m_tready;
  assign s_tready = advance;

  sfpa_entry #(.FRAC_BITS(FRAC_BITS)) u_entry (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(s_tvalid),
    .command(s_tdata[3:0]),
    .operand_a(s_tdata[35:4]),
    .operand_b(s_tdata[67:36]),
    .dout(chain[0])
  );

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    sfpa_div_cell #(.Steps(2)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .din(chain[i]), .dout(chain[i+1])
    );
  end

  always_comb begin
    item_t t;
    logic [63:0] q;
    logic signed [64:0] sq;
    t = chain[Cells];
    q = t.quo;
    sq = t.quo_neg ? -65'(q) : 65'(q);
    out_data = {3'd0, t.dz, t.sat, t.gt, t.eq, t.lt, t.value};
    if (t.command == CMD_DIV && !t.dz) begin
      if (sq > 65'sh7fffffff) begin
        out_data[31:0] = 32'h7fffffff;
        out_data[35] = 1'b1;
      end else if (sq < -65'sh80000000) begin
        out_data[31:0] = 32'h80000000;
        out_data[35] = 1'b1;
      end else begin
        out_data[31:0] = sq[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= chain[Cells].valid;
      m_tdata <= out_data;
    end
  end

  assign m_tvalid = out_valid;
endmodule

// ===== dv/tb_top.sv =====
// Testbench for the saturating fixed-point ALU: random and directed stream traffic with scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import sfpa_pkg::*;

  localparam int FracBits = 8;
  localparam int Latency = 34;
  localparam int NumRandom = 1500;

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        sat;
    logic        dz;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int mismatches;
    int checked;

    function logic signed [31:0] clamp(input logic signed [65:0] v, inout logic sat);
      if (v > 66'sd2147483647) begin
        sat = 1'b1;
        return 32'sh7fffffff;
      end
      if (v < -66'sd2147483648) begin
        sat = 1'b1;
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    function alu_result_t compute(input logic [3:0] cmd, input logic signed [31:0] a,
                                  input logic signed [31:0] b);
      alu_result_t r;
      logic signed [65:0] wa;
      logic signed [65:0] wb;
      logic signed [65:0] w;
      logic s;
      r = '0;
      s = 1'b0;
      wa = a;
      wb = b;
      case (cmd)
        CMD_ADD: r.value = clamp(wa + wb, s);
        CMD_SUB: r.value = clamp(wa - wb, s);
        CMD_MUL: begin
          w = (wa * wb) >>> FracBits;
          r.value = clamp(w, s);
        end
        CMD_DIV: begin
          if (b == 0) r.dz = 1'b1;
          else begin
            // SystemVerilog signed division truncates toward zero.
            w = (wa <<< FracBits) / wb;
            r.value = clamp(w, s);
          end
        end
        CMD_CMP: begin
          r.lt = a < b;
          r.eq = a == b;
          r.gt = a > b;
        end
        CMD_MIN: r.value = (a < b) ? a : b;
        CMD_MAX: r.value = (a > b) ? a : b;
        CMD_ABS: r.value = clamp((wa < 0) ? -wa : wa, s);
        CMD_INC: r.value = clamp(wa + 1, s);
        CMD_DEC: r.value = clamp(wa - 1, s);
        CMD_FROM_INT: r.value = clamp(wa <<< FracBits, s);
        CMD_TO_INT: r.value = a >>> FracBits;
        default: r = '0;
      endcase
      r.sat = s;
      return r;
    endfunction

    function void note_operation(input logic [71:0] data);
      pending.push_back(compute(data[3:0], data[35:4], data[67:36]));
    endfunction

    function void check_result(input logic [39:0] data);
      alu_result_t got;
      alu_result_t want;
      got = {data[31:0], data[32], data[33], data[34], data[35], data[36]};
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp value=%h lt%b eq%b gt%b sat%b dz%b,",
                    " got value=%h lt%b eq%b gt%b sat%b dz%b"},
                   want.value, want.lt, want.eq, want.gt, want.sat, want.dz,
                   got.value, got.lt, got.eq, got.gt, got.sat, got.dz);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  alu_scoreboard board = new();
  int sent;
  bit quiet;          // no idling on either side
  bit hold_sink;      // receiver held off by the stimulus

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  saturating_fixed_point_alu #(.FRAC_BITS(FracBits)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_operation(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  int hold_count;
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_sink) begin
      hold_count <= hold_count + 1;
      m_tready <= 1'b0;
    end else m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);
  end

  task automatic send_operation(input logic [3:0] cmd, input logic [31:0] a,
                                input logic [31:0] b);
    while (!quiet && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, b, a, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff - $urandom_range(2);
      1: return 32'h80000000 + $urandom_range(2);
      2: return $urandom_range(4) - 2;
      3: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
      4: return {{24{$urandom_range(1) == 1}}, 8'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  localparam logic [31:0] MaxW = 32'h7fffffff;
  localparam logic [31:0] MinW = 32'h80000000;

  initial begin
    logic [3:0] cmd;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: extremes, every command, divide by zero, saturation corners.
    send_operation(CMD_ADD, MaxW, 32'd1);
    send_operation(CMD_SUB, MinW, 32'd1);
    send_operation(CMD_MUL, MaxW, MaxW);
    send_operation(CMD_MUL, MinW, MinW);
    send_operation(CMD_MUL, 32'hffffffff, 32'd1);
    send_operation(CMD_DIV, 32'd100, 32'd0);
    send_operation(CMD_DIV, MinW, 32'hffffffff);
    send_operation(CMD_DIV, 32'hfffffff9, 32'd2);
    send_operation(CMD_CMP, MinW, MaxW);
    send_operation(CMD_CMP, 32'd5, 32'd5);
    send_operation(CMD_CMP, MaxW, MinW);
    send_operation(CMD_MIN, 32'd7, 32'd7);
    send_operation(CMD_MAX, MinW, MaxW);
    send_operation(CMD_ABS, MinW, 32'd0);
    send_operation(CMD_ABS, 32'hfffffffe, 32'd0);
    send_operation(CMD_INC, MaxW, 32'd0);
    send_operation(CMD_DEC, MinW, 32'd0);
    send_operation(CMD_FROM_INT, 32'h00800000, 32'd0);
    send_operation(CMD_FROM_INT, 32'hff7fffff, 32'd0);
    send_operation(CMD_TO_INT, 32'hffffff01, 32'd0);
    send_operation(4'd12, MaxW, MaxW);
    send_operation(4'd15, 32'hffffffff, 32'hffffffff);
    // Sender pauses until every result is back.
    drain();
    // Receiver holds off while the sender keeps offering, filling the pipeline.
    hold_sink = 1'b1;
    fork
      begin
        while (hold_count < 200) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 80; i++) send_operation(CMD_MUL, pick_operand(), pick_operand());
    join
    for (int i = 0; i < NumRandom; i++) begin
      quiet = (i >= 600 && i < 900);
      cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      send_operation(cmd, pick_operand(), pick_operand());
    end
    quiet = 1'b0;
    drain();
    repeat (Latency + 10) @(posedge clk);
    $display("Sent %0d operations over all commands,", sent);
    $display("incl. a pipeline-full stall and a drain pause; %0d results checked, %0d mismatches.",
             board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("** saturating_fixed_point_alu: PASSED **");
    end else begin
      $display("** saturating_fixed_point_alu: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("** saturating_fixed_point_alu: FAILED **");
    $finish;
  end
endmodule

// ===== saturating_fixed_point_alu.f =====
sv/sfpa_pkg.sv
sv/sfpa_div_cell.sv
sv/sfpa_entry.sv
sv/saturating_fixed_point_alu.sv
dv/tb_top.sv
